>>> hw/rtl/motion_command_sequencer_macros.svh
// Assertion shorthands for the motion command sequencer.
`ifndef MOTION_COMMAND_SEQUENCER_MACROS_SVH
`define MOTION_COMMAND_SEQUENCER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MCS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/mcs_pkg.sv
`timescale 1ns / 1ps

package mcs_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ENC_RES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROBOT_W = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_D = 2'd2;

  localparam logic [15:0] ENC_RES_RST = 16'd360;
  localparam logic [11:0] ROBOT_W_RST = 12'd200;
  localparam logic [11:0] WHEEL_D_RST = 12'd60;

  // operations
  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_START  = 3'd1;
  localparam logic [2:0] OP_PAUSE  = 3'd2;
  localparam logic [2:0] OP_RESUME = 3'd3;
  localparam logic [2:0] OP_STOP   = 3'd4;

  // strategy commands
  localparam logic [2:0] CMD_MOVE_TICKS = 3'd0;
  localparam logic [2:0] CMD_MOVE_TURNS = 3'd1;
  localparam logic [2:0] CMD_ROTATE     = 3'd2;
  localparam logic [2:0] CMD_DELAY      = 3'd3;
  localparam logic [2:0] CMD_END        = 3'd4;

  // motor actions
  localparam logic [2:0] ACT_NONE   = 3'd0;
  localparam logic [2:0] ACT_MOVE   = 3'd1;
  localparam logic [2:0] ACT_ESTOP  = 3'd2;
  localparam logic [2:0] ACT_HALT   = 3'd3;
  localparam logic [2:0] ACT_RESUME = 3'd4;

  // run modes
  localparam logic [2:0] M_WAIT_START = 3'd0;
  localparam logic [2:0] M_EXECUTE    = 3'd1;
  localparam logic [2:0] M_WAITING    = 3'd2;
  localparam logic [2:0] M_INTERRUPT  = 3'd3;
  localparam logic [2:0] M_PAUSED     = 3'd4;
  localparam logic [2:0] M_RESUME     = 3'd5;
  localparam logic [2:0] M_STOPPED    = 3'd6;

  // completion checks
  localparam logic [1:0] CHK_NONE   = 2'd0;
  localparam logic [1:0] CHK_MOTORS = 2'd1;
  localparam logic [1:0] CHK_DELAY  = 2'd2;
  localparam logic [1:0] CHK_ANGLE  = 2'd3;

  localparam int ANGLE_TOL = 5;
  // 5 * 360 / 8: rotation ticks = enc * width * deg / (ROT_DEN_K * diam)
  localparam int ROT_DEN_K = 225;

  localparam int DIV_W     = 60;
  localparam int DEN_W     = 20;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  localparam logic [31:0] INT32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] INT32_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [2:0]         operation;
    logic [2:0]         command_code;
    logic signed [31:0] command_value;
    logic               obstacle_right;
    logic               obstacle_left;
    logic               right_done;
    logic               left_done;
    logic signed [15:0] heading_deg;
    logic [31:0]        time_ms;
  } mcs_in_t;

  typedef struct packed {
    logic [2:0]         right_action;
    logic signed [31:0] right_ticks;
    logic [2:0]         left_action;
    logic signed [31:0] left_ticks;
    logic               heading_reset;
    logic               take_next_command;
    logic [2:0]         mode;
  } mcs_out_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic div_start;
    logic fin;
    logic commit;
  } mcs_cmd_t;

  typedef struct packed {
    logic need_rot;
    logic div_done;
    logic out_free;
  } mcs_stat_t;

endpackage

>>> hw/rtl/motion_command_sequencer.sv
// Motion command sequencer for a two-wheel base. One item at a time: an item
// is taken, worked on and its single result is placed in the output register,
// after which the next item is taken (it may be taken while that result still
// waits). Most items pass from acceptance through the S_MUL and S_COMMIT states
// to their result; a tick that issues a rotation also passes S_MUL2, S_DIV and
// S_FIN, waiting in S_DIV for the bit-serial 60-bit divider that
// turns degrees into wheel ticks, one quotient bit per cycle. Configuration
// writes are always taken and must be issued while the block is idle.
`timescale 1ns / 1ps

`include "motion_command_sequencer_macros.svh"

module motion_command_sequencer import mcs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  mcs_in_t               in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output mcs_out_t              out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  mcs_cmd_t  cmd;
  mcs_stat_t stat;

  assign cfg_ready = 1'b1;

  mcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  mcs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_item   (in_item),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  `MCS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "accepted item did not make the block busy")

  `MCS_ASSERT_NOW(a_hreset_moves, clk, rst_n, out_valid && out_item.heading_reset, (out_item.right_action == ACT_MOVE) && (out_item.left_action == ACT_MOVE), "heading reset without a rotation move")

  `MCS_ASSERT_NOW(a_next_mode, clk, rst_n, out_valid && out_item.take_next_command, (out_item.mode == M_EXECUTE) || (out_item.mode == M_WAITING) || (out_item.mode == M_STOPPED), "strategy advance with unexpected mode")

  `MCS_ASSERT_NOW(a_ticks_only_on_move, clk, rst_n, out_valid && (out_item.right_action != ACT_MOVE), out_item.right_ticks == 32'sd0, "right tick count without a move")

endmodule

>>> hw/rtl/mcs_div.sv
`timescale 1ns / 1ps

module mcs_div import mcs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient,
  output logic [DEN_W-1:0] remainder
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0]     acc_r;
  logic [DEN_W-1:0]     rem_r;
  logic [DEN_W-1:0]     den_r;

  logic [DEN_W:0]   trial;
  logic             q_bit;
  logic [DEN_W-1:0] rem_nxt;

  always_comb begin
    trial = {rem_r, acc_r[DIV_W-1]};
    q_bit = (trial >= {1'b0, den_r});
    if (q_bit) begin
      rem_nxt = DEN_W'(trial - {1'b0, den_r});
    end else begin
      rem_nxt = trial[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      acc_r <= {acc_r[DIV_W-2:0], q_bit};
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = acc_r;
  assign remainder = rem_r;

endmodule

>>> hw/rtl/mcs_ctrl.sv
`timescale 1ns / 1ps

module mcs_ctrl import mcs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  mcs_stat_t stat,
  output mcs_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_MUL2,
    S_DIV,
    S_FIN,
    S_COMMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r;
  logic   accept;

  assign accept = in_valid && !in_stall_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_MUL;
      end
      S_MUL: begin
        state_nxt = stat.need_rot ? S_MUL2 : S_COMMIT;
      end
      S_MUL2: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_stall_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= (state_nxt != S_IDLE);
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.load      = accept;
    cmd.mul       = (state_r == S_MUL);
    cmd.div_start = (state_r == S_MUL2);
    cmd.fin       = (state_r == S_FIN);
    cmd.commit    = (state_r == S_COMMIT) && stat.out_free;
  end

  assign in_stall = in_stall_r;

endmodule

>>> hw/rtl/mcs_dp.sv
`timescale 1ns / 1ps

module mcs_dp import mcs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mcs_cmd_t              cmd,
  output mcs_stat_t             stat,
  input  mcs_in_t               in_item,
  input  logic                  cfg_wr,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  out_stall,
  output logic                  out_valid,
  output mcs_out_t              out_item
);

  // configuration
  logic [15:0] enc_r;
  logic [11:0] width_r;
  logic [11:0] diam_r;

  // sequencer state
  logic [2:0]  run_mode_r, run_mode_nxt;
  logic [1:0]  check_kind_r, check_kind_nxt;
  logic [31:0] delay_start_r, delay_start_nxt;
  logic [31:0] delay_length_r, delay_length_nxt;
  logic [31:0] target_angle_r, target_angle_nxt;

  // item and arithmetic
  mcs_in_t            item_r;
  logic [27:0]        p1_r;
  logic [DEN_W-1:0]   den_r;
  logic signed [48:0] turns_r;
  logic [31:0]        pos_r;
  logic [31:0]        neg_r;

  logic     out_valid_r;
  mcs_out_t out_r;
  mcs_out_t res;

  logic signed [31:0] value;
  logic [31:0]        mag;
  logic               value_pos;
  logic [11:0]        diam_eff;
  logic signed [48:0] turns_a;
  logic signed [48:0] turns_b;
  logic [DIV_W-1:0]   num;
  logic               div_done;
  logic [DIV_W-1:0]   quo;
  logic [DEN_W-1:0]   rem;
  logic [DIV_W:0]     ceil_q;
  logic [31:0]        turns_sat;
  logic               turns_fit;
  logic [16:0]        hmag;
  logic signed [33:0] rot_diff;
  logic               obstacle;
  logic               both_done;
  logic               wait_done;
  logic               out_free;

  assign value     = item_r.command_value;
  assign mag       = value[31] ? (~value + 32'd1) : value;
  assign value_pos = !value[31] && (value != 32'sd0);
  assign diam_eff  = (diam_r == 12'd0) ? 12'd1 : diam_r;
  assign turns_a   = 49'(value);
  assign turns_b   = 49'($signed({1'b0, enc_r}));
  assign num       = {32'd0, p1_r} * {28'd0, mag};
  assign ceil_q    = {1'b0, quo} + (DIV_W + 1)'(rem != '0);

  assign turns_fit = (turns_r[48:31] == {18{turns_r[31]}});
  assign turns_sat = turns_fit ? turns_r[31:0] : (turns_r[48] ? INT32_MIN : INT32_MAX);

  assign hmag     = item_r.heading_deg[15] ? (~{1'b1, item_r.heading_deg} + 17'd1)
                                           : {1'b0, item_r.heading_deg};
  assign rot_diff = $signed({2'b00, target_angle_r}) - $signed({17'd0, hmag});

  assign obstacle  = item_r.obstacle_right || item_r.obstacle_left;
  assign both_done = item_r.right_done && item_r.left_done;

  assign out_free = !out_valid_r || !out_stall;

  mcs_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (num),
    .divisor   (den_r),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rem)
  );

  always_comb begin
    stat          = '0;
    stat.need_rot = (item_r.operation == OP_TICK) && (run_mode_r == M_EXECUTE) &&
                    (item_r.command_code == CMD_ROTATE);
    stat.div_done = div_done;
    stat.out_free = out_free;
  end

  always_comb begin
    case (check_kind_r)
      CHK_MOTORS: wait_done = both_done;
      CHK_DELAY:  wait_done = ((item_r.time_ms - delay_start_r) >= delay_length_r);
      CHK_ANGLE:  wait_done = (rot_diff <= $signed(34'(ANGLE_TOL))) || both_done;
      default:    wait_done = 1'b1;
    endcase
  end

  always_comb begin
    res              = '0;
    res.right_action = ACT_NONE;
    res.left_action  = ACT_NONE;
    run_mode_nxt     = run_mode_r;
    check_kind_nxt   = check_kind_r;
    delay_start_nxt  = delay_start_r;
    delay_length_nxt = delay_length_r;
    target_angle_nxt = target_angle_r;
    case (item_r.operation)
      OP_START:  run_mode_nxt = M_EXECUTE;
      OP_PAUSE:  run_mode_nxt = M_PAUSED;
      OP_RESUME: run_mode_nxt = M_RESUME;
      OP_STOP:   run_mode_nxt = M_STOPPED;
      OP_TICK: begin
        case (run_mode_r)
          M_EXECUTE: begin
            res.take_next_command = 1'b1;
            case (item_r.command_code)
              CMD_MOVE_TICKS: begin
                res.right_action = ACT_MOVE;
                res.left_action  = ACT_MOVE;
                res.right_ticks  = value;
                res.left_ticks   = value;
                check_kind_nxt   = CHK_MOTORS;
                run_mode_nxt     = M_WAITING;
              end
              CMD_MOVE_TURNS: begin
                res.right_action = ACT_MOVE;
                res.left_action  = ACT_MOVE;
                res.right_ticks  = turns_sat;
                res.left_ticks   = turns_sat;
                check_kind_nxt   = CHK_MOTORS;
                run_mode_nxt     = M_WAITING;
              end
              CMD_ROTATE: begin
                res.heading_reset = 1'b1;
                res.right_action  = ACT_MOVE;
                res.left_action   = ACT_MOVE;
                res.right_ticks   = value_pos ? pos_r : neg_r;
                res.left_ticks    = value_pos ? neg_r : pos_r;
                target_angle_nxt  = mag;
                check_kind_nxt    = CHK_ANGLE;
                run_mode_nxt      = M_WAITING;
              end
              CMD_DELAY: begin
                delay_start_nxt  = item_r.time_ms;
                delay_length_nxt = value;
                check_kind_nxt   = CHK_DELAY;
                run_mode_nxt     = M_WAITING;
              end
              CMD_END: begin
                run_mode_nxt = M_STOPPED;
              end
              default: begin
              end
            endcase
          end
          M_WAITING: begin
            if (wait_done) begin
              run_mode_nxt     = M_EXECUTE;
              res.right_action = ACT_HALT;
              res.left_action  = ACT_HALT;
            end else if (obstacle) begin
              run_mode_nxt     = M_INTERRUPT;
              res.right_action = ACT_ESTOP;
              res.left_action  = ACT_ESTOP;
            end
          end
          M_INTERRUPT: begin
            if (obstacle) begin
              res.right_action = ACT_ESTOP;
              res.left_action  = ACT_ESTOP;
            end else begin
              res.right_action = ACT_RESUME;
              res.left_action  = ACT_RESUME;
              run_mode_nxt     = M_WAITING;
            end
          end
          M_RESUME:     run_mode_nxt = M_INTERRUPT;
          M_WAIT_START: run_mode_nxt = run_mode_r;
          M_PAUSED:     run_mode_nxt = run_mode_r;
          M_STOPPED:    run_mode_nxt = run_mode_r;
          default:      run_mode_nxt = M_STOPPED;
        endcase
      end
      default: begin
      end
    endcase
    res.mode = run_mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enc_r          <= ENC_RES_RST;
      width_r        <= ROBOT_W_RST;
      diam_r         <= WHEEL_D_RST;
      run_mode_r     <= M_WAIT_START;
      check_kind_r   <= CHK_NONE;
      delay_start_r  <= '0;
      delay_length_r <= '0;
      target_angle_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_index)
          CFG_ENC_RES: enc_r   <= cfg_data;
          CFG_ROBOT_W: width_r <= cfg_data[11:0];
          CFG_WHEEL_D: diam_r  <= cfg_data[11:0];
          default: begin
          end
        endcase
      end
      if (cmd.commit) begin
        run_mode_r     <= run_mode_nxt;
        check_kind_r   <= check_kind_nxt;
        delay_start_r  <= delay_start_nxt;
        delay_length_r <= delay_length_nxt;
        target_angle_r <= target_angle_nxt;
        out_valid_r    <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_item;
    if (cmd.mul) begin
      p1_r    <= {12'd0, enc_r} * {16'd0, width_r};
      den_r   <= {8'd0, diam_eff} * DEN_W'(ROT_DEN_K);
      turns_r <= turns_a * turns_b;
    end
    if (cmd.fin) begin
      pos_r <= (quo > DIV_W'(INT32_MAX)) ? INT32_MAX : quo[31:0];
      neg_r <= (ceil_q > (DIV_W + 1)'(INT32_MIN)) ? INT32_MIN : (~ceil_q[31:0] + 32'd1);
    end
    if (cmd.commit) out_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
